// File: hw/rtl/time_command_line_parser_assert.svh
// ---------------------------------------------------------------------------
// Time command line parser - assertion macros
// Shared property templates, clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef TIME_COMMAND_LINE_PARSER_ASSERT_SVH
`define TIME_COMMAND_LINE_PARSER_ASSERT_SVH

// same-cycle implication
`define TCLP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tclp assertion failed");

// next-cycle implication
`define TCLP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tclp assertion failed");

`endif

// File: hw/rtl/tclp_pkg.sv
// ---------------------------------------------------------------------------
// tclp_pkg
// Types and constants shared by the time command line parser.
// ---------------------------------------------------------------------------
package tclp_pkg;

  // only the first PARSE_LEN characters are ever inspected by the parser
  localparam int PARSE_LEN   = 10;
  localparam int PARSE_IDX_W = 4;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_PR_LO = 8'h20;
  localparam logic [7:0] CH_PR_HI = 8'h7E;
  localparam logic [7:0] CH_T_UC  = 8'h54;
  localparam logic [7:0] CH_T_LC  = 8'h74;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [6:0] MAX_HOUR = 7'd23;
  localparam logic [6:0] MAX_MIN  = 7'd59;

  typedef enum logic [2:0] {
    ST_IGNORED = 3'd0,
    ST_STORED  = 3'd1,
    ST_ERASED  = 3'd2,
    ST_TIME    = 3'd3,
    ST_ERROR   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_APPEND = 2'd1,
    OP_ERASE  = 2'd2,
    OP_CLEAR  = 2'd3
  } line_op_t;

  typedef struct packed {
    line_op_t   op;
    logic [7:0] ch;
  } line_cmd_t;

  typedef logic [PARSE_LEN-1:0][7:0] line_head_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } parse_res_t;

endpackage

// File: hw/rtl/tclp_line.sv
// ---------------------------------------------------------------------------
// tclp_line
// Line buffer: character count plus the leading characters of the line.
// ---------------------------------------------------------------------------
module tclp_line import tclp_pkg::*; #(
  parameter int LEN_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,      // config write
  input  logic             cmd_vld,
  input  line_cmd_t        cmd,
  output logic [LEN_W-1:0] len,
  output line_head_t       head
);

  logic [LEN_W-1:0] len_r, len_nxt;
  line_head_t       head_r;

  always_comb begin
    len_nxt = len_r;
    if (clr) begin
      len_nxt = '0;
    end else if (cmd_vld) begin
      unique case (cmd.op)
        OP_APPEND: len_nxt = len_r + 1'b1;
        OP_ERASE:  len_nxt = len_r - 1'b1;
        OP_CLEAR:  len_nxt = '0;
        OP_NONE:   len_nxt = len_r;
        default:   len_nxt = len_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  // entries past the parse window are never read, so they are not kept
  always_ff @(posedge clk) begin
    if (cmd_vld && !clr && cmd.op == OP_APPEND && len_r < LEN_W'(PARSE_LEN)) begin
      head_r[len_r[PARSE_IDX_W-1:0]] <= cmd.ch;
    end
  end

  assign len  = len_r;
  assign head = head_r;

endmodule

// File: hw/rtl/tclp_parse.sv
// ---------------------------------------------------------------------------
// tclp_parse
// Checks the T=HH:MM:SS pattern and converts the three digit pairs.
// ---------------------------------------------------------------------------
module tclp_parse import tclp_pkg::*; (
  input  line_head_t head,
  output parse_res_t res
);

  logic [PARSE_LEN-1:0] dig;
  logic [6:0]           hh, mm, ss;
  logic                 shape_ok;

  function automatic logic [6:0] pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [6:0] h;
    h = {3'b0, hi[3:0]};
    return (h << 3) + (h << 1) + {3'b0, lo[3:0]};
  endfunction

  always_comb begin
    for (int i = 0; i < PARSE_LEN; i++) begin
      dig[i] = (head[i] >= CH_ZERO) && (head[i] <= CH_NINE);
    end
  end

  assign shape_ok = (head[0] == CH_T_UC || head[0] == CH_T_LC) && head[1] == CH_EQ &&
                    head[4] == CH_COLON && head[7] == CH_COLON &&
                    dig[2] && dig[3] && dig[5] && dig[6] && dig[8] && dig[9];

  assign hh = pair(head[2], head[3]);
  assign mm = pair(head[5], head[6]);
  assign ss = pair(head[8], head[9]);

  assign res.ok     = shape_ok && hh <= MAX_HOUR && mm <= MAX_MIN && ss <= MAX_MIN;
  assign res.hour   = hh[4:0];
  assign res.minute = mm[5:0];
  assign res.second = ss[5:0];

endmodule

// File: hw/rtl/time_command_line_parser.sv
// ---------------------------------------------------------------------------
// time_command_line_parser
// Collects received characters into a line and parses T=HH:MM:SS commands.
// ---------------------------------------------------------------------------
//
//  channel | dir | word
//  --------+-----+-----------------------------------------------------------
//  in_     | in  | one received character byte
//  out_    | out | one result word per character: status, time, line count
//  cfg_    | in  | enable bit; every write clears the line
//
//  Cycles: one word per clock sustained while out_tready stays high; a
//  character is registered on accept and its result is then registered
//  in the output register, which raises out_tvalid.
//  Reset: rst_n synchronous, active low; clears the line and the enable.
//  Stalls: a held output blocks the input stage only once both stages
//  are full; in_tready follows out_tready combinationally.
//
module time_command_line_parser import tclp_pkg::*; #(
  parameter int LINE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] char_in

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [2:0] status, [7:3] hour, [13:8] minute,
                                   // [19:14] second, [24:20] line_count, rest 0

  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data  // enabled
);

`include "time_command_line_parser_assert.svh"

  // count must hold LINE_DEPTH and still offer the five result bits
  localparam int CNT_W = $clog2(LINE_DEPTH + 1);
  localparam int LEN_W = (CNT_W > 5) ? CNT_W : 5;

  // --- enable register ------------------------------------------------------
  logic enabled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
    end else if (cfg_wr_en) begin
      enabled_r <= cfg_wr_data;
    end
  end

  // --- input register -------------------------------------------------------
  logic       s1_vld_r;
  logic [7:0] s1_char_r;
  logic       s1_fire;
  logic       in_fire;
  logic       out_vld_r;

  assign s1_fire   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_tdata;
    end
  end

  // --- line state and parser ------------------------------------------------
  logic [LEN_W-1:0] len;
  line_head_t       head;
  parse_res_t       pres;
  line_cmd_t        cmd;

  tclp_line #(
    .LEN_W (LEN_W)
  ) u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (cfg_wr_en),
    .cmd_vld (s1_fire),
    .cmd     (cmd),
    .len     (len),
    .head    (head)
  );

  tclp_parse u_parse (
    .head (head),
    .res  (pres)
  );

  // --- character decode -----------------------------------------------------
  logic             is_eol, is_erase, is_print, full, time_ok;
  status_t          status;
  logic [LEN_W-1:0] len_after;

  assign is_eol   = s1_char_r == CH_CR || s1_char_r == CH_LF;
  assign is_erase = s1_char_r == CH_BS || s1_char_r == CH_DEL;
  assign is_print = s1_char_r >= CH_PR_LO && s1_char_r <= CH_PR_HI;
  assign full     = len >= LEN_W'(LINE_DEPTH);
  assign time_ok  = pres.ok && len == LEN_W'(PARSE_LEN);

  always_comb begin
    status = ST_IGNORED;
    cmd.op = OP_NONE;
    cmd.ch = s1_char_r;
    if (enabled_r) begin
      priority if (is_eol) begin
        status = time_ok ? ST_TIME : ST_ERROR;
        cmd.op = OP_CLEAR;
      end else if (is_erase) begin
        if (len != '0) begin
          status = ST_ERASED;
          cmd.op = OP_ERASE;
        end
      end else if (is_print) begin
        if (!full) begin
          status = ST_STORED;
          cmd.op = OP_APPEND;
        end
      end else begin
        // other non-printable bytes are dropped
        status = ST_IGNORED;
        cmd.op = OP_NONE;
      end
    end
  end

  always_comb begin
    unique case (cmd.op)
      OP_APPEND: len_after = len + 1'b1;
      OP_ERASE:  len_after = len - 1'b1;
      OP_CLEAR:  len_after = '0;
      default:   len_after = len;
    endcase
  end

  // --- result register ------------------------------------------------------
  status_t    out_status_r;
  logic [4:0] out_hour_r;
  logic [5:0] out_min_r;
  logic [5:0] out_sec_r;
  logic [4:0] out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_status_r <= status;
      out_hour_r   <= (status == ST_TIME) ? pres.hour   : 5'd0;
      out_min_r    <= (status == ST_TIME) ? pres.minute : 6'd0;
      out_sec_r    <= (status == ST_TIME) ? pres.second : 6'd0;
      out_cnt_r    <= len_after[4:0];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_cnt_r, out_sec_r, out_min_r, out_hour_r, out_status_r};

  // --- checks ---------------------------------------------------------------
  `TCLP_ASSERT_IMP(a_len_bound, 1'b1, len <= LEN_W'(LINE_DEPTH))
  `TCLP_ASSERT_IMP(a_time_range, out_vld_r && out_status_r == ST_TIME,
                   out_hour_r <= 5'd23 && out_min_r <= 6'd59 && out_sec_r <= 6'd59)
  `TCLP_ASSERT_IMP(a_no_time, out_vld_r && out_status_r != ST_TIME,
                   out_hour_r == 5'd0 && out_min_r == 6'd0 && out_sec_r == 6'd0)
  `TCLP_ASSERT_IMP(a_commit_clears, out_vld_r &&
                   (out_status_r == ST_TIME || out_status_r == ST_ERROR),
                   out_cnt_r == 5'd0)
  `TCLP_ASSERT_NXT(a_append_grows, s1_fire && cmd.op == OP_APPEND && !cfg_wr_en,
                   len == LEN_W'($past(len) + 1'b1))

endmodule

// File: sim/time_command_line_parser_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// time_command_line_parser_test
// Streams characters into the line parser and checks every result word
// against a cycle-free model of the line buffer and the T=HH:MM:SS parser.
// ---------------------------------------------------------------------------
module time_command_line_parser_test import tclp_pkg::*;;

  localparam int LINE_DEPTH   = 16;
  localparam int RANDOM_ITEMS = 1230;  // non-ignored words in the random part
  localparam int LONG_HOLD    = 300;   // cycles of back-pressure on out_
  localparam int QUIET_TAIL   = 150;   // last words run with no idling
  localparam int DRAIN_CYCLES = 8;     // margin after the last word is back

  // One result word, in the order of the fields in out_tdata.
  typedef struct packed {
    status_t    status;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] count;
  } line_result_t;

  // Directed row: either an enable write or a character. Rows with
  // typed set carry their own expected word; the rest use the model.
  typedef struct packed {
    logic         cfg;
    logic [7:0]   val;
    logic         typed;
    line_result_t want;
  } dir_row_t;

  localparam int NUM_DIRECTED = 22;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [7:0] char_in
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;    // [2:0] status, [7:3] hour, [13:8] minute,
                             // [19:14] second, [24:20] line_count
  logic        cfg_wr_en;
  logic        cfg_wr_data;  // enabled

  // Model state: line buffer, fill level and the enable bit.
  logic [7:0]  held [LINE_DEPTH];
  int          line_len;
  bit          parse_on;

  line_result_t expected_results [$];
  int          mismatch_count;
  int          items_sent;
  int          busy_items;   // words that did something (not ignored)
  bit          quiet;        // no idling on either side
  bit          hold_long;    // asks the receiver for one long stall

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    // disabled after reset: everything ignored
    '{1'b0, 8'h41,    1'b1, '{ST_IGNORED, 5'd0,  6'd0,  6'd0,  5'd0}},
    '{1'b1, 8'h01,    1'b0, '0},
    // erase and commit on an empty line
    '{1'b0, CH_BS,    1'b1, '{ST_IGNORED, 5'd0,  6'd0,  6'd0,  5'd0}},
    '{1'b0, CH_CR,    1'b1, '{ST_ERROR,   5'd0,  6'd0,  6'd0,  5'd0}},
    // byte extremes are non-printable
    '{1'b0, 8'h00,    1'b1, '{ST_IGNORED, 5'd0,  6'd0,  6'd0,  5'd0}},
    '{1'b0, 8'hFF,    1'b1, '{ST_IGNORED, 5'd0,  6'd0,  6'd0,  5'd0}},
    // printable range edges, then a malformed commit
    '{1'b0, CH_PR_LO, 1'b1, '{ST_STORED,  5'd0,  6'd0,  6'd0,  5'd1}},
    '{1'b0, CH_PR_HI, 1'b1, '{ST_STORED,  5'd0,  6'd0,  6'd0,  5'd2}},
    '{1'b0, CH_LF,    1'b1, '{ST_ERROR,   5'd0,  6'd0,  6'd0,  5'd0}},
    // latest possible time, with one erase and retype on the way
    '{1'b0, "T",      1'b0, '0},
    '{1'b0, "=",      1'b0, '0},
    '{1'b0, "2",      1'b0, '0},
    '{1'b0, "3",      1'b0, '0},
    '{1'b0, ":",      1'b0, '0},
    '{1'b0, "5",      1'b0, '0},
    '{1'b0, "9",      1'b0, '0},
    '{1'b0, ":",      1'b0, '0},
    '{1'b0, "5",      1'b0, '0},
    '{1'b0, "9",      1'b0, '0},
    '{1'b0, CH_DEL,   1'b1, '{ST_ERASED,  5'd0,  6'd0,  6'd0,  5'd9}},
    '{1'b0, "9",      1'b0, '0},
    '{1'b0, CH_LF,    1'b1, '{ST_TIME,    5'd23, 6'd59, 6'd59, 5'd0}}
  };

  time_command_line_parser #(
    .LINE_DEPTH(LINE_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Timeout: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------

  // Two decimal digits at pos, or -1 if either is not a digit.
  function automatic int two_dec(input int pos);
    if (held[pos] < CH_ZERO || held[pos] > CH_NINE ||
        held[pos+1] < CH_ZERO || held[pos+1] > CH_NINE) begin
      return -1;
    end
    return int'(held[pos] - CH_ZERO) * 10 + int'(held[pos+1] - CH_ZERO);
  endfunction

  // Applies one character to the model line and returns the result word.
  function automatic line_result_t apply_char(input logic [7:0] c);
    line_result_t r;
    int hh, mm, ss;
    r = '0;
    if (parse_on) begin
      if (c == CH_CR || c == CH_LF) begin
        r.status = ST_ERROR;
        if (line_len == 10) begin
          hh = two_dec(2);
          mm = two_dec(5);
          ss = two_dec(8);
          if ((held[0] == CH_T_UC || held[0] == CH_T_LC) && held[1] == CH_EQ &&
              held[4] == CH_COLON && held[7] == CH_COLON &&
              hh >= 0 && mm >= 0 && ss >= 0 &&
              hh <= MAX_HOUR && mm <= MAX_MIN && ss <= MAX_MIN) begin
            r.status = ST_TIME;
            r.hour   = 5'(hh);
            r.minute = 6'(mm);
            r.second = 6'(ss);
          end
        end
        line_len = 0;
      end else if (c == CH_BS || c == CH_DEL) begin
        if (line_len != 0) begin
          line_len--;
          r.status = ST_ERASED;
        end
      end else if (c >= CH_PR_LO && c <= CH_PR_HI) begin
        // a full line drops the character
        if (line_len < LINE_DEPTH) begin
          held[line_len] = c;
          line_len++;
          r.status = ST_STORED;
        end
      end
    end
    r.count = line_len[4:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offers one character; the expected word is queued at the accept edge.
  // in_tvalid is lowered only ahead of an idle burst, so it never gets two
  // assignments in one step.
  task automatic send_char(input logic [7:0] c, input bit typed,
                           input line_result_t want);
    line_result_t r;
    int gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    r = apply_char(c);
    expected_results.push_back(typed ? want : r);
    items_sent++;
    if (r.status != ST_IGNORED) busy_items++;
  endtask

  // Enable write, only once every queued word has come back.
  task automatic set_enable(input logic v);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    parse_on = v;
    line_len = 0;
    cfg_wr_en <= 1'b0;
  endtask

  // One random burst of characters. Mostly well-formed commands with
  // random times; the rest are near misses, overlong lines and noise.
  task automatic send_sequence();
    logic [7:0] seq [$];
    int kind, hh, mm, ss, pos, fld;
    seq.delete();
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) seq.push_back($urandom_range(0, 1) ? CH_BS : CH_DEL);
    if (kind < 80) begin
      hh = $urandom_range(0, 23);
      mm = $urandom_range(0, 59);
      ss = $urandom_range(0, 59);
      seq.push_back($urandom_range(0, 1) ? CH_T_UC : CH_T_LC);
      seq.push_back(CH_EQ);
      seq.push_back(8'(CH_ZERO + hh / 10));
      seq.push_back(8'(CH_ZERO + hh % 10));
      seq.push_back(CH_COLON);
      seq.push_back(8'(CH_ZERO + mm / 10));
      seq.push_back(8'(CH_ZERO + mm % 10));
      seq.push_back(CH_COLON);
      seq.push_back(8'(CH_ZERO + ss / 10));
      seq.push_back(8'(CH_ZERO + ss % 10));
      if (kind < 55) begin
        // typo fixed on the fly: stray char then erase
        if ($urandom_range(0, 3) == 0) begin
          pos = $urandom_range(0, seq.size());
          seq.insert(pos, $urandom_range(0, 1) ? CH_BS : CH_DEL);
          seq.insert(pos, 8'($urandom_range(CH_PR_LO, CH_PR_HI)));
        end
      end else begin
        case ($urandom_range(0, 3))
          0: seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(CH_PR_LO, CH_PR_HI));
          1: begin
            // arbitrary digit pair, often out of range
            fld = 2 + 3 * $urandom_range(0, 2);
            seq[seq.size() - 10 + fld]     = 8'($urandom_range(CH_ZERO, CH_NINE));
            seq[seq.size() - 10 + fld + 1] = 8'($urandom_range(CH_ZERO, CH_NINE));
          end
          2: seq.delete($urandom_range(0, seq.size() - 1));
          default: seq.insert($urandom_range(0, seq.size()),
                              8'($urandom_range(CH_PR_LO, CH_PR_HI)));
        endcase
      end
      seq.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    end else if (kind < 90) begin
      // up to 20 characters, often enough to hit the full-line drop
      repeat ($urandom_range(12, 20)) seq.push_back(8'($urandom_range(CH_PR_LO, CH_PR_HI)));
      if ($urandom_range(0, 1)) seq.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    end else begin
      repeat ($urandom_range(1, 8)) seq.push_back(8'($urandom_range(0, 255)));
    end
    foreach (seq[i]) send_char(seq[i], 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: random stall bursts, one long hold on request.
  // ---------------------------------------------------------------------
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    line_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: %h", out_tdata);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status",     want.status, out_tdata[2:0]);
        check_field("hour",       want.hour,   out_tdata[7:3]);
        check_field("minute",     want.minute, out_tdata[13:8]);
        check_field("second",     want.second, out_tdata[19:14]);
        check_field("line_count", want.count,  out_tdata[24:20]);
        check_field("padding",    0,           out_tdata[31:25]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    bit phase_enable [6];
    int target;
    phase_enable   = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 1'b0;
    line_len       = 0;
    parse_on       = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    busy_items     = 0;
    quiet          = 1'b0;
    hold_long      = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg) begin
        set_enable(directed_rows[i].val[0]);
      end else begin
        send_char(directed_rows[i].val, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Phases end mid-line at random, so back-to-back enable writes also
    // check that a write clears a partial line. One phase runs disabled.
    busy_items = 0;
    for (int p = 0; p < 6; p++) begin
      set_enable(phase_enable[p]);
      if (p == 0) hold_long = 1'b1;
      target = phase_enable[p] ? busy_items + RANDOM_ITEMS / 5 : items_sent + 40;
      while (phase_enable[p] ? busy_items < target : items_sent < target) begin
        if (p == 5 && target - busy_items < QUIET_TAIL) quiet = 1'b1;
        send_sequence();
      end
    end

    in_tvalid <= 1'b0;
    quiet = 1'b1;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
